[src/sbra_pkg.sv]
// Shared constants and types for the sweep bin running average block.
package sbra_pkg;

  // Default sizes of the bin store
  localparam int unsigned DEF_BIN_COUNT = 256;
  localparam int unsigned DEF_DIST_BITS = 16;

  // Reset values of the sweep registers
  localparam logic [7:0] RST_SWEEP_MIN  = 8'd20;
  localparam logic [7:0] RST_SWEEP_MAX  = 8'd160;
  localparam logic [7:0] RST_SWEEP_STEP = 8'd1;

  // Stream and configuration widths
  localparam int unsigned IN_W    = 16;
  localparam int unsigned OUT_W   = 72;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 8;

  // Divisor width: sweep count plus one
  localparam int unsigned DEN_W = 17;

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_SWEEP_MIN  = 2'd0,
    CFG_SWEEP_MAX  = 2'd1,
    CFG_SWEEP_STEP = 2'd2
  } cfg_reg_e;

endpackage

[src/sbra_div.sv]
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module sbra_div #(
  parameter int unsigned NUM_W = 33,
  parameter int unsigned DEN_W = sbra_pkg::DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   shift_rem;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Bring down the next numerator bit and trial-subtract
  assign shift_rem = {rem_q, quo_q[NUM_W-1]};
  assign diff      = shift_rem - {1'b0, den_q};
  assign fits      = shift_rem >= {1'b0, den_q};

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: numerator shifts out while quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : shift_rem[DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[src/sweep_bin_running_average_top.sv]
// Top level of the sweep bin running average block.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid/tready     | tdata: distance
//  m_axis   | out       | m_axis_tvalid/tready     | tdata: bin, value, max, changed,
//           |           |                          |        next position, sweep count
//  cfg      | in        | cfg_valid_i/cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A zero reading is taken and dropped. A non-zero reading runs the shared bit-serial
// divider once for the bin and once for the average, and the scan reads one bin from
// the store per cycle. Before the first reversal the average divide is skipped.
// Reset clears control state only; the bin store has no reset.
// One beat is worked at a time; a finished result waits in the output register while
// the next beat is accepted, and the write-back stalls only if that register is full.
module sweep_bin_running_average_top #(
  parameter int unsigned BIN_COUNT = sbra_pkg::DEF_BIN_COUNT,
  parameter int unsigned DIST_BITS = sbra_pkg::DEF_DIST_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // fields from bit 0 up: distance[15:0]
  input  logic [sbra_pkg::IN_W-1:0]     s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // fields from bit 0 up: bin_index[7:0], bin_value[23:8], max_distance[39:24],
  // max_changed[40], next_position[48:41], sweep_count[64:49], zero fill[71:65]
  output logic [sbra_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sbra_pkg::CFG_A_W-1:0]  cfg_index_i,
  input  logic [sbra_pkg::CFG_D_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(BIN_COUNT);
  localparam int unsigned DEN_W = sbra_pkg::DEN_W;
  localparam int unsigned NUM_W = DIST_BITS + DEN_W;
  localparam logic [NUM_W-1:0] BIN_LAST_N = NUM_W'(BIN_COUNT - 1);
  localparam logic [IDX_W-1:0] BIN_LAST   = IDX_W'(BIN_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIN,
    ST_SCAN,
    ST_MUL,
    ST_AVG,
    ST_DONE
  } state_e;

  state_e state_q;

  // Configuration and architectural state
  logic [7:0]           cfg_min_q;
  logic [7:0]           cfg_max_q;
  logic [7:0]           cfg_step_q;
  logic [7:0]           position_q;
  logic                 moving_down_q;
  logic [IDX_W-1:0]     highest_q;
  logic [DIST_BITS-1:0] running_max_q;
  logic [15:0]          sweeps_q;

  // Per-beat working registers
  logic [DIST_BITS-1:0] reading_q;
  logic [IDX_W-1:0]     bin_q;
  logic [DIST_BITS-1:0] scan_max_q;
  logic [DIST_BITS-1:0] old_q;
  logic [DIST_BITS-1:0] stored_q;
  logic                 changed_q;
  logic [IDX_W-1:0]     scan_addr_q;
  logic                 scan_issued_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_tag_q;

  // Output register
  logic                 out_valid_q;
  logic [7:0]           out_bin_q;
  logic [15:0]          out_value_q;
  logic [15:0]          out_max_q;
  logic                 out_changed_q;
  logic [7:0]           out_pos_q;
  logic [15:0]          out_count_q;

  // Bin store
  logic [DIST_BITS-1:0] mem [BIN_COUNT];
  logic [DIST_BITS-1:0] rd_data_q;
  logic                 mem_we;

  // Divider interface
  logic                 div_start;
  logic [NUM_W-1:0]     div_num;
  logic [DEN_W-1:0]     div_den;
  logic                 div_busy;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quo;

  logic                 in_accept;
  logic [DIST_BITS-1:0] reading;
  logic [7:0]           step_eff;
  logic [7:0]           pos_off;
  logic [IDX_W-1:0]     bin_sel;
  logic [DIST_BITS-1:0] cand;
  logic [NUM_W-1:0]     avg_num;
  logic                 out_free;

  logic signed [10:0]   pos_p;
  logic signed [10:0]   step_s;
  logic signed [10:0]   step2_s;
  logic signed [10:0]   min_s;
  logic signed [10:0]   max_s;
  logic signed [10:0]   pos_a;
  logic signed [10:0]   pos_b;
  logic                 bounce;
  logic                 md_next;
  logic [7:0]           pos_next;
  logic [15:0]          sweeps_next;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign reading       = DIST_BITS'(s_axis_tdata);
  assign step_eff      = (cfg_step_q == 8'd0) ? 8'd1 : cfg_step_q;
  assign pos_off       = (position_q >= cfg_min_q) ? (position_q - cfg_min_q) : 8'd0;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign mem_we        = (state_q == ST_DONE) && out_free;

  // Clamp the divided offset to the last bin
  assign bin_sel = (div_quo > BIN_LAST_N) ? BIN_LAST : div_quo[IDX_W-1:0];

  // Current bin counts with the raw reading during the scan
  assign cand = (rd_tag_q == bin_q) ? reading_q : rd_data_q;

  // Weighted sum for the running average
  assign avg_num = NUM_W'(old_q) * NUM_W'(sweeps_q) + NUM_W'(reading_q);

  // Share the divider between the bin and the average
  assign div_start = (in_accept && (reading != '0)) ||
                     ((state_q == ST_MUL) && (sweeps_q != 16'd0));
  assign div_num   = (state_q == ST_IDLE) ? NUM_W'(pos_off) : avg_num;
  assign div_den   = (state_q == ST_IDLE) ? DEN_W'(step_eff) : (DEN_W'(sweeps_q) + 1'b1);

  // Step the position and bounce at the limits
  always_comb begin
    pos_p   = $signed({3'b000, position_q});
    step_s  = $signed({3'b000, step_eff});
    step2_s = $signed({2'b00, step_eff, 1'b0});
    min_s   = $signed({3'b000, cfg_min_q});
    max_s   = $signed({3'b000, cfg_max_q});
    pos_a   = moving_down_q ? (pos_p - step_s) : (pos_p + step_s);
    bounce  = (pos_a < min_s) || (pos_a > max_s);
    md_next = moving_down_q ^ bounce;
    pos_b   = pos_a;
    if (bounce) begin
      pos_b = md_next ? (pos_a - step2_s) : (pos_a + step2_s);
    end
    if (pos_b < 11'sd0) begin
      pos_next = 8'd0;
    end else if (pos_b > 11'sd255) begin
      pos_next = 8'd255;
    end else begin
      pos_next = pos_b[7:0];
    end
    sweeps_next = sweeps_q;
    if (bounce && (sweeps_q != 16'hFFFF)) begin
      sweeps_next = sweeps_q + 16'd1;
    end
  end

  sbra_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Bin store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[bin_q] <= stored_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[scan_addr_q];
  end

  // Sequencer with control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cfg_min_q     <= sbra_pkg::RST_SWEEP_MIN;
      cfg_max_q     <= sbra_pkg::RST_SWEEP_MAX;
      cfg_step_q    <= sbra_pkg::RST_SWEEP_STEP;
      position_q    <= sbra_pkg::RST_SWEEP_MIN;
      moving_down_q <= 1'b0;
      highest_q     <= '0;
      running_max_q <= '0;
      sweeps_q      <= '0;
      scan_addr_q   <= '0;
      scan_issued_q <= 1'b0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      // Register writes
      if (cfg_valid_i) begin
        case (sbra_pkg::cfg_reg_e'(cfg_index_i))
          sbra_pkg::CFG_SWEEP_MIN:  cfg_min_q  <= cfg_data_i;
          sbra_pkg::CFG_SWEEP_MAX:  cfg_max_q  <= cfg_data_i;
          sbra_pkg::CFG_SWEEP_STEP: cfg_step_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Drop the output beat once taken
      if (mem_we) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      rd_vld_q <= (state_q == ST_SCAN) && !scan_issued_q;

      case (state_q)
        ST_IDLE: begin
          if (in_accept && (reading != '0)) begin
            state_q <= ST_BIN;
          end
        end
        ST_BIN: begin
          if (div_done) begin
            if (bin_sel > highest_q) begin
              highest_q <= bin_sel;
            end
            scan_addr_q   <= '0;
            scan_issued_q <= 1'b0;
            state_q       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle up to the highest bin
          if (!scan_issued_q) begin
            if (scan_addr_q == highest_q) begin
              scan_issued_q <= 1'b1;
            end else begin
              scan_addr_q <= scan_addr_q + 1'b1;
            end
          end
          if (scan_issued_q && !rd_vld_q) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          running_max_q <= scan_max_q;
          state_q       <= (sweeps_q == 16'd0) ? ST_DONE : ST_AVG;
        end
        ST_AVG: begin
          if (div_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            position_q    <= pos_next;
            moving_down_q <= md_next;
            sweeps_q      <= sweeps_next;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Per-beat payload
  always_ff @(posedge clk_i) begin
    rd_tag_q <= scan_addr_q;
    if (in_accept) begin
      reading_q <= reading;
    end
    if ((state_q == ST_BIN) && div_done) begin
      bin_q      <= bin_sel;
      scan_max_q <= '0;
    end
    if (rd_vld_q) begin
      if (cand > scan_max_q) begin
        scan_max_q <= cand;
      end
      if (rd_tag_q == bin_q) begin
        old_q <= rd_data_q;
      end
    end
    if (state_q == ST_MUL) begin
      changed_q <= (scan_max_q != running_max_q);
      stored_q  <= reading_q;
    end
    if ((state_q == ST_AVG) && div_done) begin
      stored_q <= div_quo[DIST_BITS-1:0];
    end
    if (mem_we) begin
      out_bin_q     <= 8'(bin_q);
      out_value_q   <= 16'(stored_q);
      out_max_q     <= 16'(running_max_q);
      out_changed_q <= changed_q;
      out_pos_q     <= pos_next;
      out_count_q   <= sweeps_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_count_q, out_pos_q, out_changed_q,
                          out_max_q, out_value_q, out_bin_q};

`ifndef NO_ASSERTIONS
  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (rd_tag_q <= highest_q))
    else $error("scan read beyond highest bin");

  a_bin_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (bin_q <= highest_q))
    else $error("current bin not covered by scan");

  a_write_posts_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> out_valid_q)
    else $error("store write without output beat");

  a_first_sweep_skips_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MUL) && (sweeps_q == 16'd0)) |=> (state_q == ST_DONE))
    else $error("average divide started on first sweep");
`endif

endmodule
